[hw/rtl/srs_pkg.sv]
// ----------------------------------------------------------------------------
// srs_pkg: shared types and helpers for the scissor rectangle stack
// Holds the stack entry layout, operation and fault codes, the shift command
// of the cell row, and the saturation helper for Q15.8 values.
// ----------------------------------------------------------------------------
package srs_pkg;

  // Width of every Q15.8 coordinate.
  localparam int unsigned FX_W = 24;

  typedef logic signed [FX_W-1:0] fx_t;

  // Operation codes of an input beat.
  typedef enum logic [1:0] {
    KIND_PUSH    = 2'd0,
    KIND_POP     = 2'd1,
    KIND_DISABLE = 2'd2,
    KIND_CULL    = 2'd3
  } kind_t;

  // Fault codes of a result beat.
  typedef enum logic [1:0] {
    FAULT_NONE      = 2'd0,
    FAULT_POP_EMPTY = 2'd1,
    FAULT_PUSH_FULL = 2'd2
  } fault_t;

  // Move of the cell row.
  typedef enum logic [1:0] {
    SHIFT_HOLD = 2'd0,
    SHIFT_PUSH = 2'd1,
    SHIFT_POP  = 2'd2
  } shift_t;

  // One stack entry; ok marks a live scissor, via marks the screen path.
  typedef struct packed {
    logic via;
    logic ok;
    fx_t  left;
    fx_t  bottom;
    fx_t  width;
    fx_t  height;
  } entry_t;

  // Fill level of the stack as seen by the operation unit.
  typedef struct packed {
    logic empty;
    logic single;
    logic full;
  } level_t;

  // Payload of one result beat.
  typedef struct packed {
    logic   scissor_on;
    fx_t    active_x;
    fx_t    active_y;
    fx_t    active_w;
    fx_t    active_h;
    logic   active_via_screen;
    logic   is_outside;
    logic   no_scissor;
    fault_t fault;
  } result_t;

  // Clamp a 26-bit signed difference to the signed 24-bit range.
  function automatic fx_t sat_fx(input logic signed [FX_W+1:0] v);
    logic signed [FX_W+1:0] hi;
    logic signed [FX_W+1:0] lo;
    hi = {3'b000, {(FX_W-1){1'b1}}};
    lo = {3'b111, {(FX_W-1){1'b0}}};
    if (v > hi) begin
      return {1'b0, {(FX_W-1){1'b1}}};
    end else if (v < lo) begin
      return {1'b1, {(FX_W-1){1'b0}}};
    end else begin
      return v[FX_W-1:0];
    end
  endfunction

endpackage

[hw/rtl/srs_if.sv]
// ----------------------------------------------------------------------------
// srs_if: request and response channels of the scissor rectangle stack
// Both are valid/ready channels; a beat moves when valid and ready are high
// at a rising clock edge.
// ----------------------------------------------------------------------------
interface srs_req_if;
  import srs_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] kind;
  fx_t        pos_x;
  fx_t        pos_y;
  fx_t        size_w;
  fx_t        size_h;
  logic       via_screen;
  logic       skip_clip;
  fx_t        query_xmax;
  fx_t        query_ymax;

  modport source (
    output valid, kind, pos_x, pos_y, size_w, size_h, via_screen, skip_clip,
           query_xmax, query_ymax,
    input  ready
  );

  modport sink (
    input  valid, kind, pos_x, pos_y, size_w, size_h, via_screen, skip_clip,
           query_xmax, query_ymax,
    output ready
  );
endinterface

interface srs_rsp_if;
  import srs_pkg::*;

  logic       valid;
  logic       ready;
  logic       scissor_on;
  fx_t        active_x;
  fx_t        active_y;
  fx_t        active_w;
  fx_t        active_h;
  logic       active_via_screen;
  logic       is_outside;
  logic       no_scissor;
  logic [1:0] fault;

  modport source (
    output valid, scissor_on, active_x, active_y, active_w, active_h,
           active_via_screen, is_outside, no_scissor, fault,
    input  ready
  );

  modport sink (
    input  valid, scissor_on, active_x, active_y, active_w, active_h,
           active_via_screen, is_outside, no_scissor, fault,
    output ready
  );
endinterface

[hw/rtl/srs_cell.sv]
// ----------------------------------------------------------------------------
// srs_cell: one slot of the shifting stack
// Takes the entry of the neighbor above on a push and of the neighbor below
// on a pop; otherwise keeps its own entry.
// ----------------------------------------------------------------------------
module srs_cell (
  input  logic           clk,
  input  srs_pkg::shift_t shift,
  input  srs_pkg::entry_t from_up,
  input  srs_pkg::entry_t from_down,
  output srs_pkg::entry_t entry
);
  import srs_pkg::*;

  // Payload only; the fill count says which cells hold live entries.
  always_ff @(posedge clk) begin
    case (shift)
      SHIFT_PUSH: entry <= from_up;
      SHIFT_POP:  entry <= from_down;
      default:    entry <= entry;
    endcase
  end

endmodule

[hw/rtl/srs_op.sv]
// ----------------------------------------------------------------------------
// srs_op: operation unit of the scissor rectangle stack
// Decodes one request beat against the top two cells and the fill level,
// clips a pushed rectangle, runs the cull test, and forms the result beat.
// ----------------------------------------------------------------------------
module srs_op (
  input  logic            fire,
  input  logic [1:0]      kind,
  input  srs_pkg::fx_t    pos_x,
  input  srs_pkg::fx_t    pos_y,
  input  srs_pkg::fx_t    size_w,
  input  srs_pkg::fx_t    size_h,
  input  logic            via_screen,
  input  logic            skip_clip,
  input  srs_pkg::fx_t    query_xmax,
  input  srs_pkg::fx_t    query_ymax,
  input  srs_pkg::entry_t top,
  input  srs_pkg::entry_t second,
  input  srs_pkg::level_t level,
  output srs_pkg::shift_t shift,
  output srs_pkg::entry_t new_entry,
  output srs_pkg::result_t result
);
  import srs_pkg::*;

  kind_t                  op;
  logic                   top_live;
  fx_t                    tl, tb, tw, th;
  logic signed [FX_W:0]   tr, tt, ar, at;
  fx_t                    nl, nb;
  logic signed [FX_W:0]   nr, nt;
  logic signed [FX_W+1:0] dw, dh;
  entry_t                 clipped;
  logic                   hit;
  logic                   outside;
  fault_t                 fault;
  shift_t                 move;
  entry_t                 after;
  logic                   after_live;

  assign op       = kind_t'(kind);
  assign top_live = !level.empty && top.ok;
  assign tl = top.left;
  assign tb = top.bottom;
  assign tw = top.width;
  assign th = top.height;

  // Edges of the top entry and of the request at full precision.
  assign tr = {tl[FX_W-1], tl} + {tw[FX_W-1], tw};
  assign tt = {tb[FX_W-1], tb} + {th[FX_W-1], th};
  assign ar = {pos_x[FX_W-1], pos_x} + {size_w[FX_W-1], size_w};
  assign at = {pos_y[FX_W-1], pos_y} + {size_h[FX_W-1], size_h};

  // Intersection of the request with the top entry, size saturated.
  assign nl = (tl > pos_x) ? tl : pos_x;
  assign nb = (tb > pos_y) ? tb : pos_y;
  assign nr = (tr > ar) ? ar : tr;
  assign nt = (tt > at) ? at : tt;
  assign dw = {nr[FX_W], nr} - {nl[FX_W-1], nl[FX_W-1], nl};
  assign dh = {nt[FX_W], nt} - {nb[FX_W-1], nb[FX_W-1], nb};

  // Entry written by a push or a disable.
  always_comb begin
    clipped.via    = via_screen;
    clipped.ok     = 1'b1;
    clipped.left   = pos_x;
    clipped.bottom = pos_y;
    clipped.width  = size_w;
    clipped.height = size_h;
    if (!skip_clip && top_live) begin
      clipped.left   = nl;
      clipped.bottom = nb;
      clipped.width  = sat_fx(dw);
      clipped.height = sat_fx(dh);
    end
    if (op == KIND_DISABLE) begin
      new_entry = '0;
    end else begin
      new_entry = clipped;
    end
  end

  // Cull test against the top entry; touching edges overlap.
  assign hit = !(tr < pos_x || tl > query_xmax || tt < pos_y || tb > query_ymax);

  // Decode: stack move, fault, and the top entry once the beat is done.
  always_comb begin
    move       = SHIFT_HOLD;
    fault      = FAULT_NONE;
    outside    = 1'b0;
    after      = top;
    after_live = top_live;
    case (op)
      KIND_PUSH, KIND_DISABLE: begin
        if (level.full) begin
          fault = FAULT_PUSH_FULL;
        end else begin
          move       = SHIFT_PUSH;
          after      = new_entry;
          after_live = new_entry.ok;
        end
      end
      KIND_POP: begin
        if (level.empty) begin
          fault = FAULT_POP_EMPTY;
        end else begin
          move       = SHIFT_POP;
          after      = second;
          after_live = !level.single && second.ok;
        end
      end
      KIND_CULL: begin
        if (level.empty) begin
          outside = 1'b0;
        end else if (!top.ok) begin
          outside = 1'b1;
        end else begin
          outside = !hit;
        end
      end
      default: begin
        move = SHIFT_HOLD;
      end
    endcase
  end

  assign shift = fire ? move : SHIFT_HOLD;

  // Result beat; the active scissor reads as zero when there is none.
  always_comb begin
    result.scissor_on        = after_live;
    result.no_scissor        = !after_live;
    result.active_x          = after_live ? after.left   : '0;
    result.active_y          = after_live ? after.bottom : '0;
    result.active_w          = after_live ? after.width  : '0;
    result.active_h          = after_live ? after.height : '0;
    result.active_via_screen = after_live && after.via;
    result.is_outside        = outside;
    result.fault             = fault;
  end

endmodule

[hw/rtl/scissor_rect_stack_top.sv]
// ----------------------------------------------------------------------------
// scissor_rect_stack_top: bounded stack of Q15.8 scissor rectangles
// A row of cells shifts down on a push and up on a pop, so the top entry
// always sits in the first cell; one result beat follows each request beat.
// ----------------------------------------------------------------------------
//
//  Channel  Dir   Beat content
//  -------  ----  ---------------------------------------------------------
//  req      in    kind, rectangle or query box, via_screen, skip_clip
//  rsp      out   active scissor, scissor_on, no_scissor, is_outside, fault
//
// One request beat is taken per cycle while req is not stalled; its result is
// registered and shows up on rsp the cycle after. req stalls only while a
// result waits and rsp is not ready.
// Reset empties the stack at once; cell contents are left as they are.
//
module scissor_rect_stack_top #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input logic         clk,
  input logic         rst,
  srs_req_if.sink     req,
  srs_rsp_if.source   rsp
);
  import srs_pkg::*;

  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  entry_t           cells [STACK_DEPTH];
  entry_t           new_entry;
  shift_t           shift;
  level_t           level;
  result_t          result;
  result_t          rsp_data;
  logic             rsp_valid;
  logic             fire;

  // Output register parts the two sides.
  assign req.ready = !rsp_valid || rsp.ready;
  assign fire      = req.valid && req.ready;

  assign level.empty  = (count == '0);
  assign level.single = (count == CNT_W'(1));
  assign level.full   = (count == CNT_W'(STACK_DEPTH));

  srs_op u_op (
    .fire       (fire),
    .kind       (req.kind),
    .pos_x      (req.pos_x),
    .pos_y      (req.pos_y),
    .size_w     (req.size_w),
    .size_h     (req.size_h),
    .via_screen (req.via_screen),
    .skip_clip  (req.skip_clip),
    .query_xmax (req.query_xmax),
    .query_ymax (req.query_ymax),
    .top        (cells[0]),
    .second     (cells[1]),
    .level      (level),
    .shift      (shift),
    .new_entry  (new_entry),
    .result     (result)
  );

  // Row of cells; the first takes the new entry, the last refills itself.
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    entry_t up;
    entry_t down;
    if (i == 0) begin : g_first
      assign up = new_entry;
    end else begin : g_mid_up
      assign up = cells[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign down = cells[i];
    end else begin : g_mid_down
      assign down = cells[i+1];
    end
    srs_cell u_cell (
      .clk       (clk),
      .shift     (shift),
      .from_up   (up),
      .from_down (down),
      .entry     (cells[i])
    );
  end

  // Fill count follows the moves of the row.
  always_comb begin
    case (shift)
      SHIFT_PUSH: count_next = count + CNT_W'(1);
      SHIFT_POP:  count_next = count - CNT_W'(1);
      default:    count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Result register and its valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp_data <= result;
    end
  end

  assign rsp.valid             = rsp_valid;
  assign rsp.scissor_on        = rsp_data.scissor_on;
  assign rsp.active_x          = rsp_data.active_x;
  assign rsp.active_y          = rsp_data.active_y;
  assign rsp.active_w          = rsp_data.active_w;
  assign rsp.active_h          = rsp_data.active_h;
  assign rsp.active_via_screen = rsp_data.active_via_screen;
  assign rsp.is_outside        = rsp_data.is_outside;
  assign rsp.no_scissor        = rsp_data.no_scissor;
  assign rsp.fault             = rsp_data.fault;

endmodule
